### src/irpte_pkg.sv
// Package for the infrared pulse train encoder: sequencer states, register indexes, constants.
package irpte_pkg;

  localparam int PERIOD_WIDTH_DEF = 20;
  localparam int TIME_WIDTH       = 16;
  localparam int BYTE_WIDTH       = 8;
  localparam int CFG_INDEX_WIDTH  = 4;

  localparam logic [TIME_WIDTH-1:0] CHUNK_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_BITS,
    ST_TRAIL,
    ST_GAP
  } state_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_HEADER_MARK  = 4'd0,
    REG_HEADER_SPACE = 4'd1,
    REG_ONE_MARK     = 4'd2,
    REG_ONE_SPACE    = 4'd3,
    REG_ZERO_MARK    = 4'd4,
    REG_ZERO_SPACE   = 4'd5,
    REG_TRAIL_MARK   = 4'd6,
    REG_FRAME_PERIOD = 4'd7
  } reg_index_t;

endpackage

### src/ir_pulse_train_encoder.sv
// Infrared pulse-distance frame encoder: frame bytes in, mark/space pulses out.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------------
//   in      | input     | in_valid / in_ready   | frame_byte[7:0], last_byte
//   out     | output    | out_valid / out_ready | mark_time[15:0], space_time[15:0],
//           |           |                      | last_pulse
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index[3:0], cfg_data[PERIOD_WIDTH-1:0]
//
// A request is taken only while the sequencer is idle; the byte then shifts out of an
// 8-bit shift register, one bit and one pulse per cycle into the output register.
// A frame's first byte is preceded by a header pulse; after its last byte a trailer step
// charges the trailer mark, then ceil(gap / 65535) gap pulses follow (at least one).
// Output stalls hold the sequencer; the next request is taken while the final pulse
// still waits in the output register. cfg_ready is always high.
// rst (synchronous) clears state, frame and config registers and out_valid, not payloads.
module ir_pulse_train_encoder #(
  parameter int PERIOD_WIDTH = irpte_pkg::PERIOD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [irpte_pkg::BYTE_WIDTH-1:0]      frame_byte,
  input  logic                                  last_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [irpte_pkg::TIME_WIDTH-1:0]      mark_time,
  output logic [irpte_pkg::TIME_WIDTH-1:0]      space_time,
  output logic                                  last_pulse,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [irpte_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [PERIOD_WIDTH-1:0]               cfg_data
);
  import irpte_pkg::*;

  localparam int AMT_WIDTH = TIME_WIDTH + 1;

  // configuration registers
  logic [TIME_WIDTH-1:0]   header_mark, header_space, one_mark, one_space;
  logic [TIME_WIDTH-1:0]   zero_mark, zero_space, trail_mark;
  logic [PERIOD_WIDTH-1:0] frame_period;

  // sequencer state
  state_t                  state, state_next;
  logic                    in_frame, in_frame_next;
  logic [PERIOD_WIDTH-1:0] remaining, remaining_next;
  logic [BYTE_WIDTH-1:0]   shreg, shreg_next;
  logic [2:0]              bit_cnt, bit_cnt_next;
  logic                    last_flag, last_flag_next;
  logic                    first_chunk, first_chunk_next;

  // output register
  logic                    out_valid_next;
  logic [TIME_WIDTH-1:0]   mark_time_next, space_time_next;
  logic                    last_pulse_next;

  logic                    gen;
  logic [AMT_WIDTH-1:0]    amt;
  logic [PERIOD_WIDTH-1:0] amt_ext, rem_consumed;
  logic                    rem_big;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  // the output register is free to take a new pulse
  assign gen       = !out_valid || out_ready;

  // time charged against the frame by the current step
  always_comb begin
    case (state)
      ST_HEAD:  amt = {1'b0, header_mark} + {1'b0, header_space};
      ST_BITS:  amt = shreg[BYTE_WIDTH-1] ? ({1'b0, one_mark} + {1'b0, one_space})
                                          : ({1'b0, zero_mark} + {1'b0, zero_space});
      ST_TRAIL: amt = {1'b0, trail_mark};
      default:  amt = '0;
    endcase
  end

  assign amt_ext      = {{(PERIOD_WIDTH-AMT_WIDTH){1'b0}}, amt};
  // saturate the remaining frame time at zero
  assign rem_consumed = (remaining > amt_ext) ? (remaining - amt_ext) : '0;
  assign rem_big      = |remaining[PERIOD_WIDTH-1:TIME_WIDTH];

  always_comb begin
    state_next       = state;
    in_frame_next    = in_frame;
    remaining_next   = remaining;
    shreg_next       = shreg;
    bit_cnt_next     = bit_cnt;
    last_flag_next   = last_flag;
    first_chunk_next = first_chunk;
    out_valid_next   = out_valid && !out_ready;
    mark_time_next   = mark_time;
    space_time_next  = space_time;
    last_pulse_next  = last_pulse;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          shreg_next     = frame_byte;
          last_flag_next = last_byte;
          bit_cnt_next   = '0;
          if (!in_frame) begin
            // a new frame: load the period, open with the header
            remaining_next = frame_period;
            state_next     = ST_HEAD;
          end else begin
            state_next = ST_BITS;
          end
        end
      end
      ST_HEAD: begin
        if (gen) begin
          out_valid_next  = 1'b1;
          mark_time_next  = header_mark;
          space_time_next = header_space;
          last_pulse_next = 1'b0;
          remaining_next  = rem_consumed;
          in_frame_next   = 1'b1;
          state_next      = ST_BITS;
        end
      end
      ST_BITS: begin
        if (gen) begin
          out_valid_next  = 1'b1;
          mark_time_next  = shreg[BYTE_WIDTH-1] ? one_mark : zero_mark;
          space_time_next = shreg[BYTE_WIDTH-1] ? one_space : zero_space;
          remaining_next  = rem_consumed;
          // advance to the next bit, MSB first
          shreg_next      = {shreg[BYTE_WIDTH-2:0], 1'b0};
          bit_cnt_next    = bit_cnt + 3'd1;
          last_pulse_next = 1'b0;
          if (bit_cnt == 3'(BYTE_WIDTH-1)) begin
            if (last_flag) begin
              state_next = ST_TRAIL;
            end else begin
              last_pulse_next = 1'b1;
              state_next      = ST_IDLE;
            end
          end
        end
      end
      ST_TRAIL: begin
        // charge the trailer mark before splitting the gap
        remaining_next   = rem_consumed;
        first_chunk_next = 1'b1;
        state_next       = ST_GAP;
      end
      ST_GAP: begin
        if (gen) begin
          out_valid_next   = 1'b1;
          mark_time_next   = first_chunk ? trail_mark : '0;
          first_chunk_next = 1'b0;
          if (rem_big) begin
            space_time_next = CHUNK_MAX;
            last_pulse_next = 1'b0;
            remaining_next  = remaining - {{(PERIOD_WIDTH-TIME_WIDTH){1'b0}}, CHUNK_MAX};
          end else begin
            space_time_next = remaining[TIME_WIDTH-1:0];
            last_pulse_next = 1'b1;
            remaining_next  = '0;
            in_frame_next   = 1'b0;
            state_next      = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      in_frame    <= 1'b0;
      remaining   <= '0;
      bit_cnt     <= '0;
      last_flag   <= 1'b0;
      first_chunk <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      in_frame    <= in_frame_next;
      remaining   <= remaining_next;
      bit_cnt     <= bit_cnt_next;
      last_flag   <= last_flag_next;
      first_chunk <= first_chunk_next;
      out_valid   <= out_valid_next;
    end
  end

  // payload registers hold no reset
  always_ff @(posedge clk) begin
    shreg      <= shreg_next;
    mark_time  <= mark_time_next;
    space_time <= space_time_next;
    last_pulse <= last_pulse_next;
  end

  // configuration writes; an unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      header_mark  <= '0;
      header_space <= '0;
      one_mark     <= '0;
      one_space    <= '0;
      zero_mark    <= '0;
      zero_space   <= '0;
      trail_mark   <= '0;
      frame_period <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HEADER_MARK:  header_mark  <= cfg_data[TIME_WIDTH-1:0];
        REG_HEADER_SPACE: header_space <= cfg_data[TIME_WIDTH-1:0];
        REG_ONE_MARK:     one_mark     <= cfg_data[TIME_WIDTH-1:0];
        REG_ONE_SPACE:    one_space    <= cfg_data[TIME_WIDTH-1:0];
        REG_ZERO_MARK:    zero_mark    <= cfg_data[TIME_WIDTH-1:0];
        REG_ZERO_SPACE:   zero_space   <= cfg_data[TIME_WIDTH-1:0];
        REG_TRAIL_MARK:   trail_mark   <= cfg_data[TIME_WIDTH-1:0];
        REG_FRAME_PERIOD: frame_period <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### src/irpte_checker.sv
// Port-level checker for the infrared pulse train encoder, bound to the top level.
module irpte_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [irpte_pkg::TIME_WIDTH-1:0] mark_time,
  input logic [irpte_pkg::TIME_WIDTH-1:0] space_time,
  input logic                             last_pulse
);

  // reset empties the output and reopens the input
  a_reset_state: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("output not empty or input closed after reset");

  // a taken request closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened right after a request");

  // while a pulse that is not the final one waits, the request is still in work
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_pulse |-> !in_ready)
    else $error("input open before the final pulse");

  // a stalled pulse holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mark_time) && $stable(space_time)
                                && $stable(last_pulse))
    else $error("stalled pulse changed");

endmodule

bind ir_pulse_train_encoder irpte_checker u_irpte_checker (.*);
